// File: rtl/rpsd_pkg.sv
// shared constants and types for the remote packet sniffer and decoder
package rpsd_pkg;

  // packet buffering limits
  localparam int MAX_PACKET_BYTES = 32;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_LISTEN_ENABLE = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE_MS   = 2'd1;
  localparam logic [1:0] CFG_DUP_ACTION    = 2'd2;

  // configuration reset values
  localparam logic [15:0] DEBOUNCE_RESET   = 16'd500;
  localparam logic [7:0]  DUP_ACTION_RESET = 8'd5;

  // sync word searched for while learning
  localparam logic [7:0] SYNC0 = 8'hC0;
  localparam logic [7:0] SYNC1 = 8'h11;
  localparam logic [7:0] SYNC2 = 8'h00;
  localparam logic [7:0] SYNC3 = 8'h05;

  // frame markers
  localparam logic [7:0] MARK_STD  = 8'h86;
  localparam logic [7:0] MARK_JOIN = 8'h08;
  localparam logic [7:0] MARK_DUP  = 8'hC8;
  localparam logic [7:0] DUP_HDR0  = 8'h12;
  localparam logic [7:0] DUP_HDR1  = 8'h80;
  localparam logic [7:0] DUP_HDR2  = 8'h0D;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // bytes kept behind the current one for the sync search
  localparam int HIST_LEN = 10;

  // packet positions held in registers for decoding
  localparam int NUM_FIX = 11;
  localparam logic [POS_W-1:0] FIX_POS [NUM_FIX] = '{
    POS_W'(0), POS_W'(1), POS_W'(2), POS_W'(4), POS_W'(5), POS_W'(6),
    POS_W'(7), POS_W'(8), POS_W'(16), POS_W'(17), POS_W'(18)
  };
  localparam int FX_B0  = 0;
  localparam int FX_B1  = 1;
  localparam int FX_B2  = 2;
  localparam int FX_B4  = 3;
  localparam int FX_B5  = 4;
  localparam int FX_B6  = 5;
  localparam int FX_B7  = 6;
  localparam int FX_B8  = 7;
  localparam int FX_B16 = 8;
  localparam int FX_B17 = 9;
  localparam int FX_B18 = 10;

  // result codes
  localparam logic       RESULT_CAPTURE = 1'b0;
  localparam logic       RESULT_COMMAND = 1'b1;
  localparam logic [1:0] FRAME_STD      = 2'd0;
  localparam logic [1:0] FRAME_JOIN     = 2'd1;
  localparam logic [1:0] FRAME_DUP      = 2'd2;
  localparam logic [7:0] LAST_ACTION_RESET = 8'hFF;

  // view of the packet as it stands after the current byte
  typedef struct packed {
    logic [POS_W-1:0]         len;
    logic [NUM_FIX-1:0][7:0]  fix;
    logic [7:0]               act_std;
    logic [7:0]               act_join;
    logic                     learn_hit;
    logic [31:0]              learn_code;
  } frame_view_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [1:0]  frame;
    logic [7:0]  action;
    logic [31:0] code;
  } result_t;

endpackage

// File: rtl/remote_packet_sniff_and_decode.sv
// top level: input register, configuration registers, packet logic and result register
// a final byte's result is held first in the input register and then in the result register
// throughput: one byte per cycle; stalls only when the result register is held by out_ready low
// the whole packet is judged by compare logic on the final byte, the bytes being tracked as they pass
// reset: synchronous active-low rst_n clears pipeline valids, learning state and the
// configuration registers (listening off, 500 ms debounce, duplicate action 5)
module remote_packet_sniff_and_decode import rpsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [1:0]  out_frame_kind,
  output logic [7:0]  out_action_value,
  output logic [31:0] out_remote_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        listen_r;
  logic [15:0] debounce_r;
  logic [7:0]  dup_action_r;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [31:0] s1_now_r;

  logic        out_valid_r;
  result_t     out_r;

  logic        advance;
  logic        step;
  logic        cfg_xfer;
  logic        cfg_stop;
  frame_view_t view;
  logic        res_valid;
  result_t     res;

  // pipeline flow
  assign advance  = !out_valid_r || out_ready;
  assign step     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  // configuration writes
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign cfg_stop  = cfg_xfer && (cfg_index == CFG_LISTEN_ENABLE) && !cfg_data[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_r     <= 1'b0;
      debounce_r   <= DEBOUNCE_RESET;
      dup_action_r <= DUP_ACTION_RESET;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        CFG_LISTEN_ENABLE: listen_r     <= cfg_data[0];
        CFG_DEBOUNCE_MS:   debounce_r   <= cfg_data;
        CFG_DUP_ACTION:    dup_action_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_last_byte;
      s1_now_r  <= in_now_ms;
    end
  end

  // byte tracking
  rpsd_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .byte_value (s1_byte_r),
    .last_byte  (s1_last_r),
    .listen     (listen_r),
    .cfg_stop   (cfg_stop),
    .view       (view)
  );

  // packet judgment
  rpsd_decide u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .last_byte   (s1_last_r),
    .now_ms      (s1_now_r),
    .listen      (listen_r),
    .cfg_stop    (cfg_stop),
    .debounce_ms (debounce_r),
    .dup_action  (dup_action_r),
    .view        (view),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_r.kind;
  assign out_frame_kind   = out_r.frame;
  assign out_action_value = out_r.action;
  assign out_remote_code  = out_r.code;

endmodule

// File: rtl/rpsd_frame.sv
// per-packet byte tracking: position, fixed bytes, sync search and action bytes
module rpsd_frame import rpsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  input  logic        listen,
  input  logic        cfg_stop,
  output frame_view_t view
);

  logic [POS_W-1:0] pos_r;
  logic             done_r;
  logic             found_r;
  logic [31:0]      cand_r;
  logic [7:0]       hist_r [HIST_LEN];
  logic [7:0]       fix_r  [NUM_FIX];
  logic [7:0]       act_lo_r;
  logic [7:0]       act_hi_r;

  logic [POS_W-1:0] pos_eff;
  logic             stored;
  logic [POS_W-1:0] len;
  logic             found_eff;
  logic             hit;
  logic [31:0]      new_code;
  logic [7:0]       b0_cur;
  logic [7:0]       pos8;
  logic             lo_hit;
  logic             hi_hit;

  // position of this byte within its packet
  assign pos_eff   = done_r ? '0 : pos_r;
  assign stored    = (pos_eff < POS_W'(MAX_PACKET_BYTES));
  assign len       = stored ? pos_eff + POS_W'(1) : pos_eff;
  assign found_eff = done_r ? 1'b0 : found_r;
  assign pos8      = 8'(pos_eff);

  // sync word starting eight bytes back, with code bytes around it
  assign hit = stored && (pos_eff >= POS_W'(HIST_LEN)) &&
               (hist_r[7] == SYNC0) && (hist_r[6] == SYNC1) &&
               (hist_r[5] == SYNC2) && (hist_r[4] == SYNC3);
  assign new_code = {hist_r[9], hist_r[8], hist_r[0], byte_value};

  // action bytes sit at length byte minus one and at the length byte
  assign b0_cur = (stored && pos_eff == '0) ? byte_value : fix_r[FX_B0];
  assign lo_hit = stored && (b0_cur != 8'd0) && (pos8 == b0_cur - 8'd1);
  assign hi_hit = stored && (pos8 == b0_cur);

  // packet view with the current byte bypassed in
  always_comb begin
    view.len        = len;
    view.learn_hit  = found_eff || hit;
    view.learn_code = found_eff ? cand_r : new_code;
    view.act_std    = (b0_cur == 8'd0) ? 8'd0 : (lo_hit ? byte_value : act_lo_r);
    view.act_join   = hi_hit ? byte_value : act_hi_r;
    for (int k = 0; k < NUM_FIX; k++) begin
      if (FIX_POS[k] < len) begin
        view.fix[k] = (stored && pos_eff == FIX_POS[k]) ? byte_value : fix_r[k];
      end else begin
        view.fix[k] = 8'd0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (cfg_stop) begin
      pos_r  <= '0;
      done_r <= 1'b1;
    end else if (step) begin
      if (!listen) begin
        pos_r  <= '0;
        done_r <= 1'b1;
      end else begin
        pos_r   <= len;
        done_r  <= last_byte;
        found_r <= found_eff || hit;
      end
    end
  end

  // packet data
  always_ff @(posedge clk) begin
    if (step && listen && !cfg_stop) begin
      if (!found_eff && hit) begin
        cand_r <= new_code;
      end
      if (stored) begin
        hist_r[0] <= byte_value;
        for (int k = 1; k < HIST_LEN; k++) begin
          hist_r[k] <= hist_r[k-1];
        end
        for (int k = 0; k < NUM_FIX; k++) begin
          if (pos_eff == FIX_POS[k]) begin
            fix_r[k] <= byte_value;
          end
        end
        if (lo_hit) begin
          act_lo_r <= byte_value;
        end
        if (hi_hit) begin
          act_hi_r <= byte_value;
        end
      end
    end
  end

endmodule

// File: rtl/rpsd_decide.sv
// final-byte judgment: code learning, frame decoding and debounce
module rpsd_decide import rpsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        last_byte,
  input  logic [31:0] now_ms,
  input  logic        listen,
  input  logic        cfg_stop,
  input  logic [15:0] debounce_ms,
  input  logic [7:0]  dup_action,
  input  frame_view_t view,
  output logic        res_valid,
  output result_t     res
);

  logic        capture_r;
  logic [31:0] code_r;
  logic [7:0]  last_action_r;
  logic [31:0] last_time_r;

  logic [8:0]  expect_len;
  logic        len_ok;
  logic        head;
  logic        std_hit;
  logic        join_hit;
  logic        dup_hit;
  logic        found;
  logic [1:0]  frame_sel;
  logic [7:0]  act_sel;
  logic [31:0] elapsed;
  logic        bounced;
  logic        dec_ok;
  logic        judge;

  // length byte check
  assign expect_len = {1'b0, view.fix[FX_B0]} + 9'd4;
  assign len_ok     = (expect_len <= 9'(MAX_PACKET_BYTES)) && (expect_len <= 9'(view.len));

  // frame matches, later ones win
  assign head = (view.fix[FX_B4] == FILL_BYTE) && (view.fix[FX_B5] == FILL_BYTE) &&
                (view.fix[FX_B6] == code_r[15:8]) && (view.fix[FX_B7] == code_r[7:0]);
  assign std_hit  = head && (view.fix[FX_B8] == MARK_STD);
  assign join_hit = head && (view.fix[FX_B8] == MARK_JOIN);
  assign dup_hit  = (view.fix[FX_B0] == DUP_HDR0) && (view.fix[FX_B1] == DUP_HDR1) &&
                    (view.fix[FX_B2] == DUP_HDR2) &&
                    (view.fix[FX_B4] == FILL_BYTE) && (view.fix[FX_B5] == FILL_BYTE) &&
                    (view.fix[FX_B16] == code_r[15:8]) &&
                    (view.fix[FX_B17] == code_r[7:0]) &&
                    (view.fix[FX_B18] == MARK_DUP);
  assign found = std_hit || join_hit || dup_hit;

  always_comb begin
    frame_sel = FRAME_STD;
    act_sel   = view.act_std;
    if (join_hit) begin
      frame_sel = FRAME_JOIN;
      act_sel   = view.act_join;
    end
    if (dup_hit) begin
      frame_sel = FRAME_DUP;
      act_sel   = dup_action;
    end
  end

  // repeated action inside the debounce window is dropped
  assign elapsed = now_ms - last_time_r;
  assign bounced = (act_sel == last_action_r) && (elapsed < {16'd0, debounce_ms});
  assign dec_ok  = len_ok && found && !bounced;

  // result on the final byte of a packet
  assign judge     = step && listen && last_byte;
  assign res_valid = judge && (capture_r ? dec_ok : view.learn_hit);

  always_comb begin
    if (capture_r) begin
      res.kind   = RESULT_COMMAND;
      res.frame  = frame_sel;
      res.action = act_sel;
      res.code   = code_r;
    end else begin
      res.kind   = RESULT_CAPTURE;
      res.frame  = FRAME_STD;
      res.action = 8'd0;
      res.code   = view.learn_code;
    end
  end

  // learned code and debounce history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_r     <= 1'b0;
      code_r        <= '0;
      last_action_r <= LAST_ACTION_RESET;
      last_time_r   <= '0;
    end else if (cfg_stop) begin
      capture_r <= 1'b0;
    end else if (step && !listen) begin
      capture_r <= 1'b0;
    end else if (res_valid) begin
      if (capture_r) begin
        last_action_r <= act_sel;
        last_time_r   <= now_ms;
      end else begin
        capture_r <= 1'b1;
        code_r    <= view.learn_code;
      end
    end
  end

endmodule

// File: tb/sniff_decode_checker.sv
// checker: follows the byte, result and register channels, predicts reports and compares them
module sniff_decode_checker import rpsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  input  logic [31:0] in_now_ms,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_result_kind,
  input  logic [1:0]  out_frame_kind,
  input  logic [7:0]  out_action_value,
  input  logic [31:0] out_remote_code,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          reports_waiting,
  output int          reports_seen
);

  // register copies
  logic        listen_on;
  logic [15:0] window_ms;
  logic [7:0]  dup_action;

  // packet and remote tracking
  logic        learned;
  logic [7:0]  code [4];
  logic [7:0]  pkt_mem [MAX_PACKET_BYTES];
  int          fill;
  logic        pkt_closed;
  logic [7:0]  prev_action;
  logic [31:0] prev_time;

  // reports predicted but not yet transferred
  result_t     reports_due [$];
  int          errs = 0;
  int          seen = 0;

  // bytes outside the received part of the packet read as zero
  function automatic logic [7:0] byte_at(int p, int n);
    if (p < 0 || p >= n || p >= MAX_PACKET_BYTES) return 8'h00;
    return pkt_mem[p];
  endfunction

  function automatic logic [31:0] code_word();
    return {code[0], code[1], code[2], code[3]};
  endfunction

  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return 0;
    $error("%s mismatch: expected %0h, got %0h", name, want, got);
    return 1;
  endfunction

  task automatic drop_to_learning();
    learned    = 1'b0;
    fill       = 0;
    pkt_closed = 1'b1;
  endtask

  // first sync word at 2..n-9 gives the remote code
  task automatic search_sync(int n);
    result_t r;
    logic    found;
    found = 1'b0;
    for (int i = 2; i <= n - 9 && !found; i++) begin
      if (byte_at(i, n) == SYNC0 && byte_at(i + 1, n) == SYNC1 &&
          byte_at(i + 2, n) == SYNC2 && byte_at(i + 3, n) == SYNC3) begin
        found   = 1'b1;
        code[0] = byte_at(i - 2, n);
        code[1] = byte_at(i - 1, n);
        code[2] = byte_at(i + 7, n);
        code[3] = byte_at(i + 8, n);
      end
    end
    if (found) begin
      learned  = 1'b1;
      r.kind   = RESULT_CAPTURE;
      r.frame  = FRAME_STD;
      r.action = 8'h00;
      r.code   = code_word();
      reports_due.push_back(r);
    end
  endtask

  // length check, then standard, join/remove and duplicate frames, later ones win
  task automatic match_frame(int n, logic [31:0] now);
    result_t     r;
    int          need;
    logic        head;
    logic        hit;
    logic [1:0]  fk;
    logic [7:0]  act;
    logic [31:0] elapsed;
    need = int'(byte_at(0, n)) + 4;
    head = byte_at(4, n) == FILL_BYTE && byte_at(5, n) == FILL_BYTE &&
           byte_at(6, n) == code[2] && byte_at(7, n) == code[3];
    hit  = 1'b0;
    fk   = FRAME_STD;
    act  = FILL_BYTE;
    if (head && byte_at(8, n) == MARK_STD) begin
      act = byte_at(need - 5, n);
      fk  = FRAME_STD;
      hit = 1'b1;
    end
    if (head && byte_at(8, n) == MARK_JOIN) begin
      act = byte_at(need - 4, n);
      fk  = FRAME_JOIN;
      hit = 1'b1;
    end
    if (byte_at(0, n) == DUP_HDR0 && byte_at(1, n) == DUP_HDR1 &&
        byte_at(2, n) == DUP_HDR2 && byte_at(4, n) == FILL_BYTE &&
        byte_at(5, n) == FILL_BYTE && byte_at(16, n) == code[2] &&
        byte_at(17, n) == code[3] && byte_at(18, n) == MARK_DUP) begin
      act = dup_action;
      fk  = FRAME_DUP;
      hit = 1'b1;
    end
    // debounce: same action inside the window is dropped, time wraps
    elapsed = now - prev_time;
    if (need <= MAX_PACKET_BYTES && need <= n && hit &&
        !(act == prev_action && elapsed < {16'h0000, window_ms})) begin
      prev_time   = now;
      prev_action = act;
      r.kind      = RESULT_COMMAND;
      r.frame     = fk;
      r.action    = act;
      r.code      = code_word();
      reports_due.push_back(r);
    end
  endtask

  // one accepted byte
  task automatic absorb_byte(logic [7:0] b, logic last, logic [31:0] now);
    if (!listen_on) begin
      drop_to_learning();
    end else begin
      if (pkt_closed) begin
        fill       = 0;
        pkt_closed = 1'b0;
      end
      if (fill < MAX_PACKET_BYTES) begin
        pkt_mem[fill] = b;
        fill++;
      end
      if (last) begin
        pkt_closed = 1'b1;
        if (!learned) search_sync(fill);
        else match_frame(fill, now);
      end
    end
  endtask

  // transfers are sampled at the clock edge
  always @(posedge clk) begin : track
    result_t want;
    if (!rst_n) begin
      listen_on   = 1'b0;
      window_ms   = DEBOUNCE_RESET;
      dup_action  = DUP_ACTION_RESET;
      learned     = 1'b0;
      code        = '{default: 8'h00};
      fill        = 0;
      pkt_closed  = 1'b0;
      prev_action = LAST_ACTION_RESET;
      prev_time   = 32'h0;
      reports_due.delete();
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LISTEN_ENABLE: begin
            listen_on = cfg_data[0];
            if (!listen_on) drop_to_learning();
          end
          CFG_DEBOUNCE_MS: window_ms = cfg_data;
          CFG_DUP_ACTION:  dup_action = cfg_data[7:0];
          default: ;
        endcase
      end
      // byte transfer
      if (in_valid && in_ready) absorb_byte(in_byte_value, in_last_byte, in_now_ms);
      // result transfer against the oldest prediction
      if (out_valid && out_ready) begin
        seen++;
        if (reports_due.size() == 0) begin
          errs++;
          $error("unexpected result: kind %0h frame %0h action %0h code %0h",
                 out_result_kind, out_frame_kind, out_action_value, out_remote_code);
        end else begin
          want = reports_due.pop_front();
          errs += field_diff("result_kind", 32'(want.kind), 32'(out_result_kind));
          errs += field_diff("frame_kind", 32'(want.frame), 32'(out_frame_kind));
          errs += field_diff("action_value", 32'(want.action), 32'(out_action_value));
          errs += field_diff("remote_code", want.code, out_remote_code);
        end
      end
    end
    fail_count      <= errs;
    reports_waiting <= reports_due.size();
    reports_seen    <= seen;
  end

endmodule

// File: tb/tb_top.sv
// testbench top: clock, reset, packet stimulus, register phases and the verdict
module tb_top import rpsd_pkg::*; ();

  localparam int BYTE_TARGET   = 1500;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 16;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_last_byte = 1'b0;
  logic [31:0] in_now_ms = 32'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [1:0]  out_frame_kind;
  logic [7:0]  out_action_value;
  logic [31:0] out_remote_code;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_LISTEN_ENABLE;
  logic [15:0] cfg_data = 16'h0000;
  int          fail_count;
  int          reports_waiting;
  int          reports_seen;

  // stimulus state
  logic [7:0]  pkt [$];
  logic [7:0]  key_b2 = 8'h00;
  logic [7:0]  key_b3 = 8'h00;
  logic [7:0]  recent_act = 8'h00;
  logic [31:0] clock_ms = 32'h0;
  logic [15:0] window_now = DEBOUNCE_RESET;
  logic        listening = 1'b0;
  logic        need_learn = 1'b0;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          packets_sent = 0;
  int          phases_run = 0;
  int          cycles = 0;
  int          stall_mode = 0;
  int          stall_run = 0;

  remote_packet_sniff_and_decode dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_value    (in_byte_value),
    .in_last_byte     (in_last_byte),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_frame_kind   (out_frame_kind),
    .out_action_value (out_action_value),
    .out_remote_code  (out_remote_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  sniff_decode_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_value    (in_byte_value),
    .in_last_byte     (in_last_byte),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_frame_kind   (out_frame_kind),
    .out_action_value (out_action_value),
    .out_remote_code  (out_remote_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .reports_waiting  (reports_waiting),
    .reports_seen     (reports_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side stalls: each randomly picked mode holds for a random run before the next pick
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(32, 300);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= ((cycles % 13) < 9);
    endcase
  end

  // one byte transfer; valid stays up until taken
  task automatic push_byte(logic [7:0] b, logic last, logic [31:0] now);
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_last_byte  <= last;
    in_now_ms     <= now;
    do @(posedge clk); while (!in_ready);
    if (listening) bytes_sent++;
  endtask

  // bursts of random length with random gaps
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 15);
    end
  endtask

  task automatic send_packet(bit closed);
    logic        tail;
    logic [31:0] stamp;
    for (int i = 0; i < pkt.size(); i++) begin
      tail  = closed && (i == pkt.size() - 1);
      stamp = tail ? clock_ms : $urandom;
      pace();
      push_byte(pkt[i], tail, stamp);
    end
    packets_sent++;
  endtask

  // wait for every report, then for bytes that give none to drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // relearn forces learning state by a listen-off write first
  task automatic set_regs(bit relearn, bit listen, logic [15:0] win, logic [7:0] dup);
    logic [14:0] junk_hi;
    logic [7:0]  junk_lo;
    junk_hi = 15'($urandom);
    junk_lo = 8'($urandom);
    if (relearn) write_reg(CFG_LISTEN_ENABLE, {junk_hi, 1'b0});
    write_reg(CFG_DEBOUNCE_MS, win);
    write_reg(CFG_DUP_ACTION, {junk_lo, dup});
    write_reg(CFG_LISTEN_ENABLE, {~junk_hi, listen});
    cfg_valid  <= 1'b0;
    window_now = win;
    listening  = listen;
  endtask

  task automatic fill_random(int n);
    logic [7:0] v;
    pkt.delete();
    repeat (n) begin
      v = 8'($urandom);
      pkt.push_back(v);
    end
  endtask

  // sync word at position at, code bytes around it
  task automatic build_learn(int n, int at, bit adopt);
    fill_random(n);
    pkt[at]     = SYNC0;
    pkt[at + 1] = SYNC1;
    pkt[at + 2] = SYNC2;
    pkt[at + 3] = SYNC3;
    if (adopt) begin
      key_b2 = pkt[at + 7];
      key_b3 = pkt[at + 8];
    end
  endtask

  // command frame for the remote learned last; both adds a standard head to a duplicate
  task automatic build_cmd(logic [1:0] kind, int n, int lenb, logic [7:0] act, bit both);
    int p;
    fill_random(n);
    pkt[4] = FILL_BYTE;
    pkt[5] = FILL_BYTE;
    if (kind == FRAME_DUP) begin
      pkt[0]  = DUP_HDR0;
      pkt[1]  = DUP_HDR1;
      pkt[2]  = DUP_HDR2;
      pkt[16] = key_b2;
      pkt[17] = key_b3;
      pkt[18] = MARK_DUP;
      if (both) begin
        pkt[6] = key_b2;
        pkt[7] = key_b3;
        pkt[8] = MARK_STD;
      end
    end else begin
      pkt[0] = 8'(lenb);
      pkt[6] = key_b2;
      pkt[7] = key_b3;
      pkt[8] = (kind == FRAME_JOIN) ? MARK_JOIN : MARK_STD;
      p      = (kind == FRAME_JOIN) ? lenb : lenb - 1;
      if (p >= 9 && p < pkt.size()) pkt[p] = act;
    end
  endtask

  // repeats are common so the debounce path gets exercised
  function automatic logic [7:0] pick_action();
    logic [7:0] a;
    case ($urandom_range(0, 5))
      0, 1:    a = recent_act;
      2:       a = 8'h00;
      3:       a = 8'hFF;
      default: a = 8'($urandom);
    endcase
    recent_act = a;
    return a;
  endfunction

  // timestamp of the next final byte: mostly near the window, sometimes anywhere or wrapping
  task automatic step_clock();
    case ($urandom_range(0, 9))
      0:       clock_ms = $urandom;
      1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: clock_ms = clock_ms + $urandom_range(0, 2 * window_now + 4);
    endcase
  endtask

  task automatic random_packet();
    int pick;
    int n;
    int span;
    int lenb;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      n    = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(9, 32);
      span = ((n < MAX_PACKET_BYTES) ? n : MAX_PACKET_BYTES) - 4;
      lenb = ($urandom_range(0, 3) != 0) ? span : $urandom_range(0, span);
      build_cmd((pick < 28) ? FRAME_STD : FRAME_JOIN, n, lenb, pick_action(), 1'b0);
    end else if (pick < 70) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(19, 40) : $urandom_range(22, 32);
      build_cmd(FRAME_DUP, n, 0, 8'h00, $urandom_range(0, 4) == 0);
    end else if (pick < 80) begin
      n = $urandom_range(11, 36);
      build_learn(n, $urandom_range(2, ((n < MAX_PACKET_BYTES) ? n : MAX_PACKET_BYTES) - 9),
                  1'b0);
    end else begin
      fill_random($urandom_range(1, 40));
    end
    // broken well-formed frame
    if (pick < 70 && $urandom_range(0, 6) == 0)
      pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
    step_clock();
    send_packet(1'b1);
  endtask

  // one register setting and a run of packets under it
  task automatic run_phase();
    int          mode;
    int          n;
    bit          relearn;
    logic [15:0] win;
    logic [7:0]  dup;
    mode = $urandom_range(0, 9);
    case ($urandom_range(0, 5))
      0:       win = 16'h0000;
      1:       win = 16'hFFFF;
      2:       win = 16'($urandom_range(1, 8));
      default: win = 16'($urandom_range(0, 3000));
    endcase
    case ($urandom_range(0, 3))
      0:       dup = 8'h00;
      1:       dup = 8'hFF;
      default: dup = 8'($urandom);
    endcase
    settle();
    if (mode == 0) begin
      // listening off: bytes are dropped
      set_regs(1'b0, 1'b0, win, dup);
      need_learn = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        fill_random($urandom_range(1, 20));
        send_packet(1'b1);
      end
    end else begin
      relearn = need_learn || mode < 4;
      set_regs(relearn, 1'b1, win, dup);
      if (relearn) begin
        if ($urandom_range(0, 2) == 0) begin
          fill_random($urandom_range(1, 12));
          send_packet(1'b1);
        end
        n = $urandom_range(11, 36);
        build_learn(n, $urandom_range(2, ((n < MAX_PACKET_BYTES) ? n : MAX_PACKET_BYTES) - 9),
                    1'b1);
        send_packet(1'b1);
        need_learn = 1'b0;
      end
      repeat ($urandom_range(6, 16)) random_packet();
      // packet cut off by the next register phase
      if ($urandom_range(0, 9) == 0) begin
        fill_random($urandom_range(1, 6));
        send_packet(1'b0);
      end
    end
    phases_run++;
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // listening is off after reset
    fill_random(3);
    send_packet(1'b1);
    settle();
    set_regs(1'b0, 1'b1, DEBOUNCE_RESET, 8'h00);

    // sync in a 10-byte packet is too late to count
    build_learn(10, 2, 1'b0);
    send_packet(1'b1);
    // shortest packet that is learned
    build_learn(11, 2, 1'b1);
    send_packet(1'b1);

    // length byte 0: action read from before the packet start
    clock_ms = 32'd0;
    build_cmd(FRAME_STD, 9, 0, 8'h00, 1'b0);
    send_packet(1'b1);
    // smallest standard frame with a matching length byte
    build_cmd(FRAME_STD, 9, 5, 8'h00, 1'b0);
    send_packet(1'b1);
    // join/remove with the same action at the same time is suppressed, later accepted
    build_cmd(FRAME_JOIN, 14, 10, 8'hFF, 1'b0);
    send_packet(1'b1);
    clock_ms = 32'd2000;
    build_cmd(FRAME_JOIN, 14, 10, 8'hFF, 1'b0);
    send_packet(1'b1);

    // duplicate, repeat one ms inside the window, then at the window edge over a std head
    clock_ms = 32'd2100;
    build_cmd(FRAME_DUP, 22, 0, 8'h00, 1'b0);
    send_packet(1'b1);
    clock_ms = 32'd2599;
    build_cmd(FRAME_DUP, 22, 0, 8'h00, 1'b0);
    send_packet(1'b1);
    clock_ms = 32'd2600;
    build_cmd(FRAME_DUP, 22, 0, 8'h00, 1'b1);
    send_packet(1'b1);

    // overlong packet whose length byte points past the store
    build_cmd(FRAME_STD, 36, 29, 8'h33, 1'b0);
    send_packet(1'b1);

    // timestamp wraps between two identical actions
    clock_ms = 32'hFFFF_FFF0;
    build_cmd(FRAME_STD, 16, 12, 8'h5A, 1'b0);
    send_packet(1'b1);
    clock_ms = 32'h0000_0010;
    build_cmd(FRAME_STD, 16, 12, 8'h5A, 1'b0);
    send_packet(1'b1);

    // unfinished packet, then listening turned off
    fill_random(5);
    send_packet(1'b0);
    settle();
    set_regs(1'b1, 1'b0, 16'hFFFF, 8'hFF);
    need_learn = 1'b1;

    // random phases
    while (bytes_sent < BYTE_TARGET) run_phase();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run: %0d listened bytes in %0d packets over %0d register phases",
             bytes_sent, packets_sent, phases_run);
    $display("run: %0d captures and commands compared in %0d cycles", reports_seen, cycles);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
